// File: hw/rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  localparam int DEFAULT_ENTRIES = 16;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 31;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Miss result for a get.
  localparam logic [DATA_W-1:0] DATA_MISS = {DATA_W{1'b1}};

  typedef struct packed {
    logic load;  // capture the request item
    logic exec;  // look up and update the entry array
  } dp_ctrl_t;

  typedef struct packed {
    logic is_get;  // captured request is a get
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_core.sv
`default_nettype none
// The result strobe is registered: accepting a get item moves the controller to its execute
// state, and the edge that ends that state raises the strobe with the registered result.
// No new item is accepted while an item executes (busy is high); in the execute state the
// whole entry array is compared and its ranks updated.
// Reset: synchronous, active low; clears valid bits, ranks and occupancy at once and loads
// capacity 16, so items are taken as soon as reset is released. The receiver cannot stall.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_cmd,
  input  wire signed [lkv_pkg::KEY_W-1:0]    in_key,
  input  wire        [lkv_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0]  out_data,
  input  wire                                cfg_wr_en,
  input  wire        [lkv_pkg::CAP_W-1:0]    cfg_wr_data
);
  import lkv_pkg::*;

  dp_ctrl_t          ctrl;
  dp_stat_t          stat;
  logic [DATA_W-1:0] data_w;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_cmd      (in_cmd),
    .in_key      (in_key),
    .in_value    (in_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_hit     (out_hit),
    .out_data    (data_w)
  );

  assign out_data = data_w;

endmodule

`default_nettype wire

// File: hw/rtl/lkv_ctrl.sv
`default_nettype none

module lkv_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  output logic              out_valid,
  output lkv_pkg::dp_ctrl_t ctrl,
  input  lkv_pkg::dp_stat_t stat
);
  import lkv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.load     = start && (state_r == ST_IDLE);
    ctrl.exec     = (state_r == ST_EXEC);
    out_valid_nxt = ctrl.exec && stat.is_get;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without a preceding execute cycle");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lkv_datapath.sv
`default_nettype none

module lkv_datapath #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lkv_pkg::dp_ctrl_t                 ctrl,
  output lkv_pkg::dp_stat_t                 stat,
  input  wire                               in_cmd,
  input  wire        [lkv_pkg::KEY_W-1:0]   in_key,
  input  wire        [lkv_pkg::VALUE_W-1:0] in_value,
  input  wire                               cfg_wr_en,
  input  wire        [lkv_pkg::CAP_W-1:0]   cfg_wr_data,
  output logic                              out_hit,
  output logic       [lkv_pkg::DATA_W-1:0]  out_data
);
  import lkv_pkg::*;

  localparam int RW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Captured request item.
  logic               req_cmd_r;
  logic [KEY_W-1:0]   req_key_r;
  logic [VALUE_W-1:0] req_value_r;

  logic [CAP_W-1:0]   cap_r;

  logic [KEY_W-1:0]   key_r   [ENTRIES];
  logic [VALUE_W-1:0] value_r [ENTRIES];
  logic [RW-1:0]      rank_r  [ENTRIES];
  logic [RW-1:0]      rank_nxt[ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  logic               out_hit_r;
  logic [DATA_W-1:0]  out_data_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [ENTRIES-1:0] valid_after;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] slot;
  logic [ENTRIES-1:0] key_we;
  logic [ENTRIES-1:0] value_we;
  logic               hit_any;
  logic [RW-1:0]      hit_rank;
  logic [VALUE_W-1:0] hit_value;
  logic [RW-1:0]      last_rank;
  logic [CW-1:0]      cap_eff;
  logic               is_put;
  logic               evict;

  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_eff > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else if (cap_eff == '0) begin
      cap_eff = CW'(1);
    end
  end

  // Parallel compare; keys are unique among valid entries, so at most one matches.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req_key_r);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_r[i];
        hit_value = hit_value | value_r[i];
      end
    end
    hit_any = |match;
  end

  // Valid ranks always form 0 .. occupancy-1, so the least recent entry is the
  // one whose rank equals occupancy-1.
  always_comb begin
    last_rank = RW'(occ_r - OCC_W'(1));
    is_put    = (req_cmd_r == CMD_PUT);
    evict     = is_put && !hit_any && (CW'(occ_r) >= cap_eff);
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = valid_r[i] && (rank_r[i] == last_rank);
    end
    valid_after = evict ? (valid_r & ~victim) : valid_r;
    free        = ~valid_after;
    slot        = free & (~free + ENTRIES'(1));
  end

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    key_we    = '0;
    value_we  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (ctrl.exec) begin
      if (hit_any) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
        if (is_put) value_we = match;
      end else if (is_put) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot[i] || !valid_after[i]) begin
            rank_nxt[i] = '0;
          end else begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
        valid_nxt = valid_after | slot;
        key_we    = slot;
        value_we  = slot;
        if (!evict) occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd_r   <= in_cmd;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we[i])   key_r[i]   <= req_key_r;
      if (value_we[i]) value_r[i] <= req_value_r;
    end
    if (ctrl.exec && !is_put) begin
      out_hit_r  <= hit_any;
      out_data_r <= hit_any ? {1'b0, hit_value} : DATA_MISS;
    end
  end

  assign stat.is_get = (req_cmd_r == CMD_GET);
  assign out_hit     = out_hit_r;
  assign out_data    = out_data_r;

`ifndef NO_ASSERTIONS
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_W'($countones(valid_r)))
    else $error("occupancy does not match the number of valid entries");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_put_present: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && is_put) |=> hit_any)
    else $error("key not present after a put");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
module tb;
  import lkv_pkg::*;

  localparam int ENTRIES      = DEFAULT_ENTRIES;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 160;
  localparam int SETTLE_TICKS = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic {REQ_ITEM, REQ_CAP_WRITE} req_kind_t;

  typedef struct {
    req_kind_t              kind;
    logic [CAP_W-1:0]       cap;
    logic                   cmd;
    logic [KEY_W-1:0]       key;
    logic [VALUE_W-1:0]     value;
    bit                     idle_ok;
  } cache_req_t;

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] data;
  } lookup_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_cmd;
  logic signed [KEY_W-1:0]    in_key;
  logic [VALUE_W-1:0]         in_value;
  logic                       out_valid;
  logic                       out_hit;
  logic signed [DATA_W-1:0]   out_data;
  logic                       cfg_wr_en;
  logic [CAP_W-1:0]           cfg_wr_data;

  lru_key_value_cache_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_key      (in_key),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_hit     (out_hit),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow copy of the cache contents.
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [VALUE_W-1:0] slot_value [ENTRIES];
  bit                 slot_live  [ENTRIES];
  int                 slot_age   [ENTRIES];
  int                 live_count;
  logic [CAP_W-1:0]   cap_setting;

  cache_req_t     pending_reqs [$];
  lookup_result_t lookups_due  [$];

  int fails      = 0;
  int gap_left   = 0;
  int settle_cnt = 0;
  int cycle_cnt  = 0;

  function automatic void promote(int idx);
    int r;
    r = slot_age[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[idx] = 0;
  endfunction

  // Applies one accepted item to the shadow cache and queues the lookup result of a get.
  function automatic void predict_request(logic cmd, logic [KEY_W-1:0] key,
                                          logic [VALUE_W-1:0] value);
    int             slot;
    int             lim;
    int             victim;
    int             oldest;
    lookup_result_t res;
    slot = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (slot_live[i] && slot_key[i] == key) slot = i;
    lim = (cap_setting > ENTRIES) ? ENTRIES : ((cap_setting == 0) ? 1 : int'(cap_setting));
    if (cmd == CMD_GET) begin
      if (slot >= 0) begin
        promote(slot);
        res.hit  = 1'b1;
        res.data = {1'b0, slot_value[slot]};
      end else begin
        res.hit  = 1'b0;
        res.data = DATA_MISS;
      end
      lookups_due.push_back(res);
    end else if (slot >= 0) begin
      slot_value[slot] = value;
      promote(slot);
    end else begin
      if (live_count >= lim) begin
        victim = -1;
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        if (victim >= 0) begin
          slot_live[victim] = 1'b0;
          slot_age[victim]  = 0;
          live_count--;
        end
      end
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!slot_live[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_live[slot]  = 1'b1;
        slot_age[slot]   = 0;
        live_count++;
      end
    end
  endfunction

  task automatic add_item(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                          bit idle_ok);
    cache_req_t req;
    req.kind    = REQ_ITEM;
    req.cap     = '0;
    req.cmd     = cmd;
    req.key     = key;
    req.value   = value;
    req.idle_ok = idle_ok;
    pending_reqs.push_back(req);
  endtask

  task automatic add_cap(logic [CAP_W-1:0] cap);
    cache_req_t req;
    req.kind    = REQ_CAP_WRITE;
    req.cap     = cap;
    req.cmd     = CMD_GET;
    req.key     = '0;
    req.value   = '0;
    req.idle_ok = 1'b0;
    pending_reqs.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver. A capacity write waits until the cache has gone quiet.
  always @(posedge clk) begin : drive
    cache_req_t req;
    logic       next_start;
    logic       next_cfg;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      next_start = start;
      next_cfg   = 1'b0;
      if (start || lookups_due.size() != 0) settle_cnt = 0;
      else settle_cnt++;
      if (start && !busy) begin
        predict_request(in_cmd, in_key, in_value);
        next_start = 1'b0;
      end
      if (!next_start && !cfg_wr_en) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].kind == REQ_CAP_WRITE) begin
            if (lookups_due.size() == 0 && settle_cnt >= SETTLE_TICKS) begin
              req = pending_reqs.pop_front();
              cfg_wr_data <= req.cap;
              cap_setting = req.cap;
              next_cfg    = 1'b1;
            end
          end else begin
            req = pending_reqs.pop_front();
            in_cmd   <= req.cmd;
            in_key   <= req.key;
            in_value <= req.value;
            next_start = 1'b1;
            if (req.idle_ok && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
          end
        end
      end
      start     <= next_start;
      cfg_wr_en <= next_cfg;
    end
  end

  always @(posedge clk) begin : check
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (lookups_due.size() == 0) begin
        $error("result with none expected: hit %0d data %0d", out_hit, out_data);
        fails++;
      end else begin
        want = lookups_due.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
          fails++;
        end
        if (out_data !== want.data) begin
          $error("out_data: expected %0d, got %0d", $signed(want.data), out_data);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout: %0d items unsent, %0d results due", pending_reqs.size(),
             lookups_due.size());
      $display("FAIL lru_key_value_cache_core");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0]   cap;
    logic [KEY_W-1:0]   pool [32];
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] val;
    logic [31:0]        rnd;
    logic               cmd;
    int                 eff;
    int                 pool_n;
    bit                 idle_on;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_GET;
    in_key      = '0;
    in_value    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i]  = 0;
    end
    live_count  = 0;
    cap_setting = CAP_RESET;

    // Directed part: empty lookup, extreme keys and values, update in place, then
    // capacity lowered below occupancy and a capacity of zero.
    add_item(CMD_GET, 32'h0000_0000, '0, 1'b0);
    add_item(CMD_PUT, 32'h8000_0000, '0, 1'b0);
    add_item(CMD_PUT, 32'h7fff_ffff, '1, 1'b0);
    add_item(CMD_PUT, 32'hffff_ffff, 31'h2aaa_aaaa, 1'b0);
    add_item(CMD_GET, 32'h8000_0000, '1, 1'b0);
    add_item(CMD_GET, 32'h7fff_ffff, '0, 1'b0);
    add_item(CMD_GET, 32'hffff_ffff, '0, 1'b0);
    add_item(CMD_GET, 32'h0000_0000, '0, 1'b0);
    add_item(CMD_PUT, 32'h7fff_ffff, 31'h5555_5555, 1'b0);
    add_item(CMD_GET, 32'h7fff_ffff, '0, 1'b0);
    add_cap(5'd2);
    add_item(CMD_PUT, 32'h0000_0000, 31'd7, 1'b0);
    add_item(CMD_GET, 32'h8000_0000, '0, 1'b0);
    add_item(CMD_GET, 32'h7fff_ffff, '0, 1'b0);
    add_item(CMD_PUT, 32'h7fff_ffff, 31'd9, 1'b0);
    add_item(CMD_GET, 32'hffff_ffff, '0, 1'b0);
    add_cap(5'd0);
    add_item(CMD_PUT, 32'h0000_0001, 31'd1, 1'b0);
    add_item(CMD_PUT, 32'h0000_0002, 31'd2, 1'b0);
    add_item(CMD_GET, 32'h0000_0001, '0, 1'b0);
    add_item(CMD_GET, 32'h0000_0002, '0, 1'b0);

    // Random phases: each works on a small key set so that hits and evictions are common.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 5'd1;
        1: cap = 5'd31;
        2: cap = 5'd16;
        3: cap = 5'd17;
        4: cap = 5'd4;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      add_cap(cap);
      eff     = (cap > ENTRIES) ? ENTRIES : ((cap == 0) ? 1 : int'(cap));
      pool_n  = $urandom_range(1, eff + 6);
      idle_on = (p != PHASES - 1) && (p % 3 != 2);
      for (int k = 0; k < pool_n; k++) begin
        case ($urandom_range(0, 7))
          0: pool[k] = 32'h8000_0000;
          1: pool[k] = 32'h7fff_ffff;
          default: pool[k] = $urandom;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        key = ($urandom_range(0, 19) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
        rnd = $urandom;
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = '1;
          default: val = rnd[VALUE_W-1:0];
        endcase
        add_item(cmd, key, val, idle_on);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || start || cfg_wr_en || lookups_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("PASS lru_key_value_cache_core");
    end else begin
      $display("FAIL lru_key_value_cache_core");
    end
    $finish;
  end

endmodule
